[sv/hgnc_pkg.sv]
// Shared constants, types and helper functions of the hex grid nearest cell block.
package hgnc_pkg;

    // Fixed-point format and register limits
    localparam int FRAC_BITS   = 8;
    localparam int SEARCH_SPAN = 2;
    localparam int RAD_W       = 15;
    localparam int RAD_LOW     = ((1 << FRAC_BITS) + 5) / 10;
    localparam int RAD_HIGH    = 100 << FRAC_BITS;
    localparam int RAD_RESET   = 1280;
    localparam logic [63:0] SQRT3_Q30 = 64'd1859775393;

    // Field and datapath widths
    localparam int PT_W  = 24;
    localparam int OUT_W = 20;
    localparam int W_W   = 16;
    localparam int DEN_W = 18;
    localparam int NUM_W = 26;
    localparam int QS_W  = NUM_W + 1;
    localparam int D_W   = 22;
    localparam int SQ_W  = 2 * D_W;

    // Divider lanes
    localparam int LANES     = 3;
    localparam int LANE_ROW  = 0;
    localparam int LANE_EVEN = 1;
    localparam int LANE_ODD  = 2;

    // Configuration port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_HEX_RADIUS = '0;

    localparam logic [RAD_W-1:0] RAD_LOW_V   = RAD_W'(RAD_LOW);
    localparam logic [RAD_W-1:0] RAD_HIGH_V  = RAD_W'(RAD_HIGH);
    localparam logic [RAD_W-1:0] RAD_RESET_V = RAD_W'(RAD_RESET);
    localparam logic [W_W-1:0]   W_RESET     =
        W_W'((64'(RAD_RESET) * SQRT3_Q30 + (64'd1 << 29)) >> 30);

    localparam logic signed [QS_W-1:0] OUT_MAX_Q = QS_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [QS_W-1:0] OUT_MIN_Q = QS_W'(-(1 << (OUT_W - 1)));

    // One item in flight through the divider chain
    typedef struct packed {
        logic signed [PT_W-1:0]         x;
        logic signed [PT_W-1:0]         y;
        logic [LANES-1:0]               neg;
        logic [LANES-1:0][NUM_W-1:0]    nq;
        logic [LANES-1:0][DEN_W-1:0]    rem;
    } t_div_stage;

    // Column pitch: sqrt3 times radius, rounded half up
    function automatic logic [W_W-1:0] calc_w(input logic [RAD_W-1:0] r);
        logic [63:0] p;
        p = 64'(r) * SQRT3_Q30 + (64'd1 << 29);
        return W_W'(p >> 30);
    endfunction

    // Clamp a written radius to the legal range
    function automatic logic [RAD_W-1:0] clamp_radius(input logic [RAD_W-1:0] v);
        logic [RAD_W-1:0] c;
        c = v;
        if (v < RAD_LOW_V) begin
            c = RAD_LOW_V;
        end else if (v > RAD_HIGH_V) begin
            c = RAD_HIGH_V;
        end
        return c;
    endfunction

    // Saturate a row or column to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [QS_W-1:0] v);
        logic signed [QS_W-1:0] c;
        c = v;
        if (v < OUT_MIN_Q) begin
            c = OUT_MIN_Q;
        end else if (v > OUT_MAX_Q) begin
            c = OUT_MAX_Q;
        end
        return OUT_W'(c);
    endfunction

    // Exact square of a small signed distance
    function automatic logic [SQ_W-1:0] square(input logic signed [D_W-1:0] v);
        logic signed [SQ_W-1:0] e;
        logic signed [SQ_W-1:0] p;
        e = SQ_W'(v);
        p = e * e;
        return p;
    endfunction

endpackage

[sv/hgnc_if.sv]
// Handshake channels for points in and cells out.
interface hgnc_pt_if;
    logic                               valid;
    logic                               ready;
    logic signed [hgnc_pkg::PT_W-1:0]   point_x;
    logic signed [hgnc_pkg::PT_W-1:0]   point_y;

    modport source (output valid, point_x, point_y, input ready);
    modport sink (input valid, point_x, point_y, output ready);
endinterface

interface hgnc_cell_if;
    logic                               valid;
    logic                               ready;
    logic signed [hgnc_pkg::OUT_W-1:0]  cell_column;
    logic signed [hgnc_pkg::OUT_W-1:0]  cell_row;

    modport source (output valid, cell_column, cell_row, input ready);
    modport sink (input valid, cell_column, cell_row, output ready);
endinterface

[sv/hex_grid_nearest_cell_top.sv]
// Top level: nearest odd-row-offset hexagon cell for a fixed-point point.
// Throughput: one item per cycle while input is ready; the 26-cell divider chain and scoring pipeline never stall.
// Input is taken while the credit count of items not yet moved to the output stage is below
// the result queue depth, so a waiting result does not block new items.
// Reset (synchronous, active low) empties the pipeline and queue and sets the radius to 5.0.
module hex_grid_nearest_cell_top #(
    parameter int SEARCH_SPAN = hgnc_pkg::SEARCH_SPAN
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hgnc_pt_if.sink                           i_pt,
    hgnc_cell_if.source                       o_cell,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hgnc_pkg::ADDR_W-1:0]       paddr,
    input  logic [hgnc_pkg::DATA_W-1:0]       pwdata,
    output logic [hgnc_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int LV    = $clog2((2 * SEARCH_SPAN + 1) * (2 * SEARCH_SPAN + 1));
    localparam int PIPE  = 1 + hgnc_pkg::NUM_W + 4 + LV;
    localparam int DEPTH = 2 ** $clog2(PIPE + 3);
    localparam int CNT_W = $clog2(DEPTH) + 1;
    localparam int NUM_W = hgnc_pkg::NUM_W;
    localparam int QS_W  = hgnc_pkg::QS_W;
    localparam int PT_W  = hgnc_pkg::PT_W;

    logic [hgnc_pkg::RAD_W-1:0] r_radius;
    logic [hgnc_pkg::W_W-1:0]   r_w;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_s0_v;
    hgnc_pkg::t_div_stage       r_s0;
    hgnc_pkg::t_div_stage       n_s0;

    logic                                       w_acc;
    logic                                       w_pop;
    logic                                       w_cfg_wr;
    logic [hgnc_pkg::LANES-1:0][hgnc_pkg::DEN_W-1:0] w_den;
    logic [NUM_W:0]                             v_chain;
    hgnc_pkg::t_div_stage                       s_chain [NUM_W+1];
    logic signed [QS_W-1:0]                     w_q [hgnc_pkg::LANES];
    logic                                       w_sc_v;
    logic signed [hgnc_pkg::OUT_W-1:0]          w_sc_col;
    logic signed [hgnc_pkg::OUT_W-1:0]          w_sc_row;

    // Configuration register write and readback
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite &&
                      (paddr[hgnc_pkg::ADDR_W-1:2] == hgnc_pkg::REG_HEX_RADIUS);
    assign prdata   = (paddr[hgnc_pkg::ADDR_W-1:2] == hgnc_pkg::REG_HEX_RADIUS) ?
                      hgnc_pkg::DATA_W'(r_radius) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= hgnc_pkg::RAD_RESET_V;
            r_w      <= hgnc_pkg::W_RESET;
        end else begin
            if (w_cfg_wr) begin
                r_radius <= hgnc_pkg::clamp_radius(pwdata[hgnc_pkg::RAD_W-1:0]);
                r_w      <= hgnc_pkg::calc_w(
                                hgnc_pkg::clamp_radius(pwdata[hgnc_pkg::RAD_W-1:0]));
            end
        end
    end

    // Credit count of items accepted and not yet moved to the output stage
    assign i_pt.ready = (r_cnt < CNT_W'(DEPTH));
    assign w_acc      = i_pt.valid && i_pt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({w_acc, w_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Numerators of the row and column estimates as a sign and a value complemented when negative
    always_comb begin
        logic [NUM_W:0] a_row;
        logic [NUM_W:0] a_even;
        logic [NUM_W:0] a_odd;
        a_row  = {{(NUM_W + 1 - PT_W - 2){i_pt.point_y[PT_W-1]}}, i_pt.point_y, 2'b00}
                 - (NUM_W + 1)'(r_radius);
        a_odd  = {{(NUM_W + 1 - PT_W - 1){i_pt.point_x[PT_W-1]}}, i_pt.point_x, 1'b0};
        a_even = a_odd + (NUM_W + 1)'(r_w);
        n_s0.x = i_pt.point_x;
        n_s0.y = i_pt.point_y;
        n_s0.neg[hgnc_pkg::LANE_ROW]  = a_row[NUM_W];
        n_s0.neg[hgnc_pkg::LANE_EVEN] = a_even[NUM_W];
        n_s0.neg[hgnc_pkg::LANE_ODD]  = a_odd[NUM_W];
        n_s0.nq[hgnc_pkg::LANE_ROW]   = a_row[NUM_W] ? ~a_row[NUM_W-1:0] : a_row[NUM_W-1:0];
        n_s0.nq[hgnc_pkg::LANE_EVEN]  = a_even[NUM_W] ? ~a_even[NUM_W-1:0]
                                                      : a_even[NUM_W-1:0];
        n_s0.nq[hgnc_pkg::LANE_ODD]   = a_odd[NUM_W] ? ~a_odd[NUM_W-1:0] : a_odd[NUM_W-1:0];
        n_s0.rem = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
    end

    // Divisors: six radii for the row, two pitches for both column lanes
    assign w_den[hgnc_pkg::LANE_ROW]  = hgnc_pkg::DEN_W'({r_radius, 2'b00})
                                      + hgnc_pkg::DEN_W'({r_radius, 1'b0});
    assign w_den[hgnc_pkg::LANE_EVEN] = hgnc_pkg::DEN_W'({r_w, 1'b0});
    assign w_den[hgnc_pkg::LANE_ODD]  = hgnc_pkg::DEN_W'({r_w, 1'b0});

    // Divider chain, one quotient bit per cell
    assign v_chain[0] = r_s0_v;
    assign s_chain[0] = r_s0;

    for (genvar i = 0; i < NUM_W; i++) begin : g_cell
        hgnc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_den   (w_den),
            .i_valid (v_chain[i]),
            .i_stage (s_chain[i]),
            .o_valid (v_chain[i+1]),
            .o_stage (s_chain[i+1])
        );
    end

    // Floor quotients: negative numerators were complemented, so complement back
    always_comb begin
        for (int l = 0; l < hgnc_pkg::LANES; l++) begin
            w_q[l] = s_chain[NUM_W].neg[l] ? ~{1'b0, s_chain[NUM_W].nq[l]}
                                            : {1'b0, s_chain[NUM_W].nq[l]};
        end
    end

    hgnc_score #(
        .SPAN (SEARCH_SPAN)
    ) u_score (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v_chain[NUM_W]),
        .i_x      (s_chain[NUM_W].x),
        .i_y      (s_chain[NUM_W].y),
        .i_row0   (w_q[hgnc_pkg::LANE_ROW]),
        .i_ce0    (w_q[hgnc_pkg::LANE_EVEN]),
        .i_co0    (w_q[hgnc_pkg::LANE_ODD]),
        .i_radius (r_radius),
        .i_w      (r_w),
        .o_valid  (w_sc_v),
        .o_col    (w_sc_col),
        .o_row    (w_sc_row)
    );

    hgnc_out_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_sc_v),
        .i_col   (w_sc_col),
        .i_row   (w_sc_row),
        .o_cell  (o_cell),
        .o_pop   (w_pop)
    );

`ifndef SYNTHESIS
    // Credits never exceed the queue depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("credit count above queue depth");

    // Radius stays within the clamp limits
    a_radius_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_radius >= hgnc_pkg::RAD_LOW_V) && (r_radius <= hgnc_pkg::RAD_HIGH_V))
        else $error("radius outside limits");

    // Column pitch always matches the radius
    a_w_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w == hgnc_pkg::calc_w(r_radius))
        else $error("column pitch out of step with radius");

    // An item leaves the queue only when a credit is held for it
    a_pop_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_cnt != '0))
        else $error("queue read without a credit");
`endif

endmodule

[sv/hgnc_div_cell.sv]
// One restoring division step for the three estimate lanes, registered.
module hgnc_div_cell (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic [hgnc_pkg::LANES-1:0][hgnc_pkg::DEN_W-1:0] i_den,
    input  logic                                          i_valid,
    input  hgnc_pkg::t_div_stage                          i_stage,
    output logic                                          o_valid,
    output hgnc_pkg::t_div_stage                          o_stage
);

    logic                 r_valid;
    hgnc_pkg::t_div_stage r_stage;
    hgnc_pkg::t_div_stage n_stage;

    // Shift in the next numerator bit, subtract when it fits, shift the quotient bit in
    always_comb begin
        logic [hgnc_pkg::DEN_W:0] t;
        logic                     ge;
        n_stage = i_stage;
        for (int l = 0; l < hgnc_pkg::LANES; l++) begin
            t  = {i_stage.rem[l], i_stage.nq[l][hgnc_pkg::NUM_W-1]};
            ge = (t >= {1'b0, i_den[l]});
            n_stage.rem[l] = ge ? hgnc_pkg::DEN_W'(t - {1'b0, i_den[l]})
                                : t[hgnc_pkg::DEN_W-1:0];
            n_stage.nq[l]  = {i_stage.nq[l][hgnc_pkg::NUM_W-2:0], ge};
        end
    end

    // Advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

[sv/hgnc_score.sv]
// Candidate distance scoring and registered minimum tree.
module hgnc_score #(
    parameter int SPAN = hgnc_pkg::SEARCH_SPAN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [hgnc_pkg::PT_W-1:0]    i_x,
    input  logic signed [hgnc_pkg::PT_W-1:0]    i_y,
    input  logic signed [hgnc_pkg::QS_W-1:0]    i_row0,
    input  logic signed [hgnc_pkg::QS_W-1:0]    i_ce0,
    input  logic signed [hgnc_pkg::QS_W-1:0]    i_co0,
    input  logic [hgnc_pkg::RAD_W-1:0]          i_radius,
    input  logic [hgnc_pkg::W_W-1:0]            i_w,
    output logic                                o_valid,
    output logic signed [hgnc_pkg::OUT_W-1:0]   o_col,
    output logic signed [hgnc_pkg::OUT_W-1:0]   o_row
);

    localparam int N     = 2 * SPAN + 1;
    localparam int NC    = N * N;
    localparam int LV    = $clog2(NC);
    localparam int P     = 1 << LV;
    localparam int NODES = 2 * P - 1;
    localparam int STG   = 4 + LV;
    localparam int D_W   = hgnc_pkg::D_W;
    localparam int QS_W  = hgnc_pkg::QS_W;
    localparam int SQ_W  = hgnc_pkg::SQ_W;

    logic [STG-1:0] r_v;

    logic signed [QS_W-1:0] c_row [N];
    logic signed [QS_W-1:0] c_ce  [N];
    logic signed [QS_W-1:0] c_co  [N];
    logic [D_W-1:0]         c_py  [N];
    logic [D_W-1:0]         c_pe  [N];
    logic [D_W-1:0]         c_po  [N];

    logic signed [QS_W-1:0] r_a_row [N];
    logic signed [QS_W-1:0] r_a_ce  [N];
    logic signed [QS_W-1:0] r_a_co  [N];
    logic [D_W-1:0]         r_a_py  [N];
    logic [D_W-1:0]         r_a_pe  [N];
    logic [D_W-1:0]         r_a_po  [N];
    logic [D_W-1:0]         r_a_x2;
    logic [D_W-1:0]         r_a_y2;

    logic signed [QS_W-1:0] r_b_row [N];
    logic signed [QS_W-1:0] r_b_ce  [N];
    logic signed [QS_W-1:0] r_b_co  [N];
    logic signed [D_W-1:0]  r_b_dy  [N];
    logic signed [D_W-1:0]  r_b_dxe [N];
    logic signed [D_W-1:0]  r_b_dxo [N];

    logic signed [QS_W-1:0] r_c_row [N];
    logic signed [QS_W-1:0] r_c_ce  [N];
    logic signed [QS_W-1:0] r_c_co  [N];
    logic [SQ_W-1:0]        r_c_sy  [N];
    logic [SQ_W-1:0]        r_c_sxe [N];
    logic [SQ_W-1:0]        r_c_sxo [N];

    logic [SQ_W-1:0]        r_ns [NODES];
    logic signed [QS_W-1:0] r_nr [NODES];
    logic signed [QS_W-1:0] r_nc [NODES];

    // Candidate rows and columns, and their center offsets modulo the distance width
    always_comb begin
        logic [D_W-1:0] f;
        logic [D_W-1:0] rad;
        logic [D_W-1:0] wid;
        rad = D_W'(i_radius);
        wid = D_W'(i_w);
        for (int k = 0; k < N; k++) begin
            c_row[k] = i_row0 + QS_W'(k - SPAN);
            c_ce[k]  = i_ce0 + QS_W'(k - SPAN);
            c_co[k]  = i_co0 + QS_W'(k - SPAN);
            f        = D_W'(c_row[k]);
            c_py[k]  = (f + f + f + D_W'(2)) * rad;
            f        = D_W'(c_ce[k]);
            c_pe[k]  = {f[D_W-2:0], 1'b0} * wid;
            f        = D_W'(c_co[k]);
            c_po[k]  = {f[D_W-2:0], 1'b1} * wid;
        end
    end

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[STG-2:0], i_valid};
        end
    end

    // Offsets, differences and squares
    always_ff @(posedge i_clk) begin
        r_a_x2 <= D_W'({i_x, 1'b0});
        r_a_y2 <= D_W'({i_y, 1'b0});
        for (int k = 0; k < N; k++) begin
            r_a_row[k] <= c_row[k];
            r_a_ce[k]  <= c_ce[k];
            r_a_co[k]  <= c_co[k];
            r_a_py[k]  <= c_py[k];
            r_a_pe[k]  <= c_pe[k];
            r_a_po[k]  <= c_po[k];

            r_b_row[k] <= r_a_row[k];
            r_b_ce[k]  <= r_a_ce[k];
            r_b_co[k]  <= r_a_co[k];
            r_b_dy[k]  <= r_a_y2 - r_a_py[k];
            r_b_dxe[k] <= r_a_x2 - r_a_pe[k];
            r_b_dxo[k] <= r_a_x2 - r_a_po[k];

            r_c_row[k] <= r_b_row[k];
            r_c_ce[k]  <= r_b_ce[k];
            r_c_co[k]  <= r_b_co[k];
            r_c_sy[k]  <= hgnc_pkg::square(r_b_dy[k]);
            r_c_sxe[k] <= hgnc_pkg::square(r_b_dxe[k]);
            r_c_sxo[k] <= hgnc_pkg::square(r_b_dxo[k]);
        end
    end

    // Score the leaves in row-then-column order and reduce, lower index wins ties
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            for (int j = 0; j < N; j++) begin
                r_ns[P-1+k*N+j] <= r_c_sy[k] + (r_c_row[k][0] ? r_c_sxo[j] : r_c_sxe[j]);
                r_nr[P-1+k*N+j] <= r_c_row[k];
                r_nc[P-1+k*N+j] <= r_c_row[k][0] ? r_c_co[j] : r_c_ce[j];
            end
        end
        for (int c = NC; c < P; c++) begin
            r_ns[P-1+c] <= '1;
            r_nr[P-1+c] <= '0;
            r_nc[P-1+c] <= '0;
        end
        for (int n = 0; n < P - 1; n++) begin
            if (r_ns[2*n+2] < r_ns[2*n+1]) begin
                r_ns[n] <= r_ns[2*n+2];
                r_nr[n] <= r_nr[2*n+2];
                r_nc[n] <= r_nc[2*n+2];
            end else begin
                r_ns[n] <= r_ns[2*n+1];
                r_nr[n] <= r_nr[2*n+1];
                r_nc[n] <= r_nc[2*n+1];
            end
        end
    end

    assign o_valid = r_v[STG-1];
    assign o_row   = hgnc_pkg::sat_out(r_nr[0]);
    assign o_col   = hgnc_pkg::sat_out(r_nc[0]);

endmodule

[sv/hgnc_out_fifo.sv]
// Result queue with a registered output stage.
module hgnc_out_fifo #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic signed [hgnc_pkg::OUT_W-1:0]  i_col,
    input  logic signed [hgnc_pkg::OUT_W-1:0]  i_row,
    hgnc_cell_if.source                        o_cell,
    output logic                               o_pop
);

    localparam int AW  = $clog2(DEPTH);
    localparam int EW  = 2 * hgnc_pkg::OUT_W;

    logic [EW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_fill;
    logic          r_ov;
    logic [EW-1:0] r_data;
    logic          w_pop;

    // Move an item to the output stage when it is free or being taken
    assign w_pop = (r_fill != '0) && (!r_ov || o_cell.ready);

    // Store results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= {i_col, i_row};
        end
    end

    // Read into the output register
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_data <= r_mem[r_rp];
        end
    end

    // Pointers, fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_fill <= r_fill + (AW+1)'(1);
                2'b01:   r_fill <= r_fill - (AW+1)'(1);
                default: r_fill <= r_fill;
            endcase
            if (w_pop) begin
                r_ov <= 1'b1;
            end else if (o_cell.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_cell.valid       = r_ov;
    assign o_cell.cell_column = r_data[EW-1:hgnc_pkg::OUT_W];
    assign o_cell.cell_row    = r_data[hgnc_pkg::OUT_W-1:0];
    assign o_pop              = w_pop;

endmodule
